@@ design/dble_pkg.sv @@
package dble_pkg;

  // Pixel buffers
  localparam int MAX_PIXELS = 256;
  localparam int IDX_W      = $clog2(MAX_PIXELS);
  localparam int BANK_W     = 1;
  localparam int COLOR_W    = 8;
  localparam int PULSES     = 3 * COLOR_W;
  localparam int GRB_W      = PULSES;
  localparam int BIT_CNT_W  = $clog2(PULSES);

  // Config registers
  localparam int COUNT_W    = 9;
  localparam int TICK_W     = 15;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_SEL_W  = 3;

  localparam logic [REG_SEL_W-1:0] REG_PIXEL_COUNT     = 3'd0;
  localparam logic [REG_SEL_W-1:0] REG_ONE_HIGH_TICKS  = 3'd1;
  localparam logic [REG_SEL_W-1:0] REG_ONE_LOW_TICKS   = 3'd2;
  localparam logic [REG_SEL_W-1:0] REG_ZERO_HIGH_TICKS = 3'd3;
  localparam logic [REG_SEL_W-1:0] REG_ZERO_LOW_TICKS  = 3'd4;

  localparam logic [COUNT_W-1:0] PIXEL_COUNT_RST     = 9'd256;
  localparam logic [TICK_W-1:0]  ONE_HIGH_TICKS_RST  = 15'd32;
  localparam logic [TICK_W-1:0]  ONE_LOW_TICKS_RST   = 15'd18;
  localparam logic [TICK_W-1:0]  ZERO_HIGH_TICKS_RST = 15'd16;
  localparam logic [TICK_W-1:0]  ZERO_LOW_TICKS_RST  = 15'd34;

  // Stream layout
  localparam int S_DATA_W = 32;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 32;

  typedef enum logic [1:0] {
    ACT_SET   = 2'd0,
    ACT_SHOW  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_EMIT  = 2'd3
  } act_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef enum logic {
    STAT_OK    = 1'b0,
    STAT_RANGE = 1'b1
  } stat_t;

  typedef struct packed {
    logic [COUNT_W-1:0] pixel_count;
    logic [TICK_W-1:0]  one_high_ticks;
    logic [TICK_W-1:0]  one_low_ticks;
    logic [TICK_W-1:0]  zero_high_ticks;
    logic [TICK_W-1:0]  zero_low_ticks;
  } cfg_t;

  // Commands from the sequencer to the pulse serializer
  typedef struct packed {
    logic             load;
    logic             stat_req;
    stat_t            stat;
    logic [GRB_W-1:0] grb;
  } ser_cmd_t;

endpackage

@@ design/dble_cfg_regs.sv @@
module dble_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dble_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [dble_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [dble_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output dble_pkg::cfg_t                       cfg
);

  logic [dble_pkg::REG_SEL_W-1:0] sel;
  logic                           wr_en;

  assign pready = 1'b1;
  assign sel    = paddr[dble_pkg::APB_ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite & pready;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_count     <= dble_pkg::PIXEL_COUNT_RST;
      cfg.one_high_ticks  <= dble_pkg::ONE_HIGH_TICKS_RST;
      cfg.one_low_ticks   <= dble_pkg::ONE_LOW_TICKS_RST;
      cfg.zero_high_ticks <= dble_pkg::ZERO_HIGH_TICKS_RST;
      cfg.zero_low_ticks  <= dble_pkg::ZERO_LOW_TICKS_RST;
    end else if (wr_en) begin
      case (sel)
        dble_pkg::REG_PIXEL_COUNT:
          cfg.pixel_count <= pwdata[dble_pkg::COUNT_W-1:0];
        dble_pkg::REG_ONE_HIGH_TICKS:
          cfg.one_high_ticks <= pwdata[dble_pkg::TICK_W-1:0];
        dble_pkg::REG_ONE_LOW_TICKS:
          cfg.one_low_ticks <= pwdata[dble_pkg::TICK_W-1:0];
        dble_pkg::REG_ZERO_HIGH_TICKS:
          cfg.zero_high_ticks <= pwdata[dble_pkg::TICK_W-1:0];
        dble_pkg::REG_ZERO_LOW_TICKS:
          cfg.zero_low_ticks <= pwdata[dble_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    case (sel)
      dble_pkg::REG_PIXEL_COUNT:
        prdata = dble_pkg::APB_DATA_W'(cfg.pixel_count);
      dble_pkg::REG_ONE_HIGH_TICKS:
        prdata = dble_pkg::APB_DATA_W'(cfg.one_high_ticks);
      dble_pkg::REG_ONE_LOW_TICKS:
        prdata = dble_pkg::APB_DATA_W'(cfg.one_low_ticks);
      dble_pkg::REG_ZERO_HIGH_TICKS:
        prdata = dble_pkg::APB_DATA_W'(cfg.zero_high_ticks);
      dble_pkg::REG_ZERO_LOW_TICKS:
        prdata = dble_pkg::APB_DATA_W'(cfg.zero_low_ticks);
      default: prdata = '0;
    endcase
  end

endmodule

@@ design/dble_pixel_store.sv @@
module dble_pixel_store (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [dble_pkg::BANK_W-1:0]       wr_bank,
  input  logic [dble_pkg::IDX_W-1:0]        wr_idx,
  input  logic [dble_pkg::GRB_W-1:0]        wr_data,
  input  logic                              clr_en,
  input  logic [dble_pkg::BANK_W-1:0]       clr_bank,
  output logic                              clr_busy,
  input  logic                              rd_en,
  input  logic [dble_pkg::BANK_W-1:0]       rd_bank,
  input  logic [dble_pkg::IDX_W-1:0]        rd_idx,
  output logic [dble_pkg::GRB_W-1:0]        rd_data
);

  localparam int BANKS  = 2 ** dble_pkg::BANK_W;
  localparam int DEPTH  = BANKS * dble_pkg::MAX_PIXELS;
  localparam int ADDR_W = dble_pkg::BANK_W + dble_pkg::IDX_W;
  localparam logic [dble_pkg::IDX_W-1:0] LAST_IDX =
    dble_pkg::IDX_W'(dble_pkg::MAX_PIXELS - 1);

  logic [dble_pkg::GRB_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]          clr_addr;
  logic [ADDR_W-1:0]          clr_last;
  logic                       clr_run;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_addr;
  logic [dble_pkg::GRB_W-1:0] mem_wdata;

  assign clr_busy  = clr_run;
  assign mem_we    = clr_run || wr_en;
  assign mem_addr  = clr_run ? clr_addr : {wr_bank, wr_idx};
  assign mem_wdata = clr_run ? '0 : wr_data;

  // Clearing walk: one pixel per cycle, both banks after reset, one bank on request
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_run  <= 1'b1;
      clr_addr <= '0;
      clr_last <= {{dble_pkg::BANK_W{1'b1}}, LAST_IDX};
    end else if (clr_en) begin
      clr_run  <= 1'b1;
      clr_addr <= {clr_bank, {dble_pkg::IDX_W{1'b0}}};
      clr_last <= {clr_bank, LAST_IDX};
    end else if (clr_run) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == clr_last) begin
        clr_run <= 1'b0;
      end
    end
  end

  // Pixel memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[{rd_bank, rd_idx}];
    end
  end

endmodule

@@ design/dble_pulse_serializer.sv @@
module dble_pulse_serializer (
  input  logic                              clk,
  input  logic                              rst,
  input  dble_pkg::ser_cmd_t                cmd,
  input  dble_pkg::cfg_t                    cfg,
  output logic                              busy,
  output logic                              slot_free,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [dble_pkg::M_DATA_W-1:0]     m_tdata,   // high ticks, low ticks, zero pad
  output logic                              m_tuser,   // status
  output logic                              m_tlast
);

  localparam logic [dble_pkg::BIT_CNT_W-1:0] LAST_BIT =
    dble_pkg::BIT_CNT_W'(dble_pkg::PULSES - 1);
  localparam int PAD_W = dble_pkg::M_DATA_W - 2 * dble_pkg::TICK_W;

  logic [dble_pkg::GRB_W-1:0]     shreg;
  logic [dble_pkg::BIT_CNT_W-1:0] cnt;
  logic                           run;
  logic [dble_pkg::TICK_W-1:0]    out_hi;
  logic [dble_pkg::TICK_W-1:0]    out_lo;
  logic                           out_last;
  dble_pkg::stat_t                out_stat;

  assign slot_free = !m_tvalid || m_tready;
  assign busy      = run;

  // Control: run flag, bit counter, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.load) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run && slot_free) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_BIT) begin
          run <= 1'b0;
        end
      end
      if (cmd.stat_req || (!cmd.load && run && slot_free)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload: shift out one bit per output slot, MSB first
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shreg <= cmd.grb;
    end else if (run && slot_free) begin
      out_hi   <= shreg[dble_pkg::GRB_W-1] ? cfg.one_high_ticks : cfg.zero_high_ticks;
      out_lo   <= shreg[dble_pkg::GRB_W-1] ? cfg.one_low_ticks  : cfg.zero_low_ticks;
      out_last <= (cnt == LAST_BIT);
      out_stat <= dble_pkg::STAT_OK;
      shreg    <= {shreg[dble_pkg::GRB_W-2:0], 1'b0};
    end else if (cmd.stat_req) begin
      out_hi   <= '0;
      out_lo   <= '0;
      out_last <= 1'b1;
      out_stat <= cmd.stat;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_lo, out_hi};
  assign m_tuser = out_stat;
  assign m_tlast = out_last;

endmodule

@@ design/double_buffered_led_strip_encoder.sv @@
// Double-buffered LED strip encoder. Two 256-pixel GRB buffers are kept; set
// items draw into the back buffer, show swaps front and back and blanks the new
// back buffer, clear blanks the back buffer, and emit turns one front-buffer
// pixel into 24 pulse items (green, red, blue, each MSB first) whose high/low
// tick counts come from the one/zero timing registers. Set, show and clear,
// and any set or emit whose index is at or past the pixel count (capped at
// 256), answer with one status item. Show and clear blank the whole buffer
// one pixel per cycle behind their status item, and the next item waits until
// the blanking is done; after reset both buffers are blanked the same way,
// which holds s_tready low until both are clear. An emit in range first fetches
// the pixel from the buffer memory through its registered read port and the
// read state, then loads it into the shared shift unit, which sends it pulse by
// pulse and holds while the output is stalled. The block takes one item at a
// time: s_tready stays low until the last pulse of an emit is in the output
// register and that register is free or being read. Write the registers only
// while idle.
module double_buffered_led_strip_encoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [dble_pkg::S_DATA_W-1:0]       s_tdata,   // pixel_index, red, green, blue
  input  logic [dble_pkg::S_USER_W-1:0]       s_tuser,   // action
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [dble_pkg::M_DATA_W-1:0]       m_tdata,   // pulse_high_ticks, pulse_low_ticks
  output logic                                m_tuser,   // status
  output logic                                m_tlast,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dble_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [dble_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [dble_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int CW = dble_pkg::COLOR_W;
  localparam logic [dble_pkg::COUNT_W-1:0] MAX_COUNT =
    dble_pkg::COUNT_W'(dble_pkg::MAX_PIXELS);

  dble_pkg::cfg_t     cfg;
  dble_pkg::ser_cmd_t cmd;
  dble_pkg::state_t   state, state_next;
  dble_pkg::act_t     act;

  logic                           front_is_first, front_is_first_next;
  logic                           busy, slot_free, accept, in_range;
  logic [dble_pkg::COUNT_W-1:0]   eff_count;
  logic [dble_pkg::IDX_W-1:0]     idx;
  logic [dble_pkg::GRB_W-1:0]     grb_in, rd_data;
  logic [dble_pkg::BANK_W-1:0]    front_bank, back_bank;
  logic                           wr_en, clr_en, rd_en;
  logic [dble_pkg::BANK_W-1:0]    clr_bank;
  logic                           clr_busy;

  dble_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Unpack the input item
  assign act    = dble_pkg::act_t'(s_tuser);
  assign idx    = s_tdata[CW-1:0];
  assign grb_in = {s_tdata[3*CW-1:2*CW], s_tdata[2*CW-1:CW], s_tdata[4*CW-1:3*CW]};

  assign eff_count  = (cfg.pixel_count > MAX_COUNT) ? MAX_COUNT : cfg.pixel_count;
  assign in_range   = dble_pkg::COUNT_W'(idx) < eff_count;
  assign front_bank = front_is_first ? 1'b0 : 1'b1;
  assign back_bank  = ~front_bank;

  assign s_tready = (state == dble_pkg::ST_IDLE) && !busy && !clr_busy && slot_free;
  assign accept   = s_tvalid && s_tready;

  // Hold state and the buffer roles
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= dble_pkg::ST_IDLE;
      front_is_first <= 1'b1;
    end else begin
      state          <= state_next;
      front_is_first <= front_is_first_next;
    end
  end

  // Sequence: decode the action, drive the store and the serializer
  always_comb begin
    state_next          = state;
    front_is_first_next = front_is_first;
    wr_en               = 1'b0;
    clr_en              = 1'b0;
    clr_bank            = back_bank;
    rd_en               = 1'b0;
    cmd.load            = 1'b0;
    cmd.stat_req        = 1'b0;
    cmd.stat            = dble_pkg::STAT_OK;
    cmd.grb             = rd_data;
    case (state)
      dble_pkg::ST_IDLE: begin
        if (accept) begin
          case (act)
            dble_pkg::ACT_SET: begin
              cmd.stat_req = 1'b1;
              cmd.stat     = in_range ? dble_pkg::STAT_OK : dble_pkg::STAT_RANGE;
              wr_en        = in_range;
            end
            dble_pkg::ACT_SHOW: begin
              cmd.stat_req        = 1'b1;
              clr_en              = 1'b1;
              clr_bank            = front_bank;
              front_is_first_next = !front_is_first;
            end
            dble_pkg::ACT_CLEAR: begin
              cmd.stat_req = 1'b1;
              clr_en       = 1'b1;
            end
            dble_pkg::ACT_EMIT: begin
              if (in_range) begin
                rd_en      = 1'b1;
                state_next = dble_pkg::ST_READ;
              end else begin
                cmd.stat_req = 1'b1;
                cmd.stat     = dble_pkg::STAT_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      dble_pkg::ST_READ: begin
        cmd.load   = 1'b1;
        state_next = dble_pkg::ST_IDLE;
      end
      default: state_next = dble_pkg::ST_IDLE;
    endcase
  end

  dble_pixel_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_bank  (back_bank),
    .wr_idx   (idx),
    .wr_data  (grb_in),
    .clr_en   (clr_en),
    .clr_bank (clr_bank),
    .clr_busy (clr_busy),
    .rd_en    (rd_en),
    .rd_bank  (front_bank),
    .rd_idx   (idx),
    .rd_data  (rd_data)
  );

  dble_pulse_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .busy      (busy),
    .slot_free (slot_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

@@ tb/led_strip_pulse_checker.sv @@
`timescale 1ns / 100ps

// Watches the item, pulse and register channels of the LED strip encoder.
// Keeps its own copy of both pixel banks and the timing registers, predicts
// the pulse items of every accepted item and compares them in order.
module led_strip_pulse_checker
  import dble_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,   // pixel_index, red, green, blue
  input  logic [S_USER_W-1:0]   s_tuser,   // action
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_DATA_W-1:0]   m_tdata,   // pulse_high_ticks, pulse_low_ticks
  input  logic                  m_tuser,   // status
  input  logic                  m_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  output int                    fail_count,
  output int                    pending_count
);

  typedef struct packed {
    logic [TICK_W-1:0] hi_cnt;
    logic [TICK_W-1:0] lo_cnt;
    logic              last;
    stat_t             status;
  } pulse_t;

  pulse_t           expected_pulses[$];
  logic             front_is_a;
  logic [GRB_W-1:0] bank_a[MAX_PIXELS];
  logic [GRB_W-1:0] bank_b[MAX_PIXELS];
  cfg_t             timing;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  task automatic flag(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  function automatic logic [APB_DATA_W-1:0] reg_value(input logic [REG_SEL_W-1:0] sel);
    case (sel)
      REG_PIXEL_COUNT:     return APB_DATA_W'(timing.pixel_count);
      REG_ONE_HIGH_TICKS:  return APB_DATA_W'(timing.one_high_ticks);
      REG_ONE_LOW_TICKS:   return APB_DATA_W'(timing.one_low_ticks);
      REG_ZERO_HIGH_TICKS: return APB_DATA_W'(timing.zero_high_ticks);
      REG_ZERO_LOW_TICKS:  return APB_DATA_W'(timing.zero_low_ticks);
      default:             return '0;
    endcase
  endfunction

  task automatic write_reg(input logic [REG_SEL_W-1:0] sel, input logic [APB_DATA_W-1:0] value);
    case (sel)
      REG_PIXEL_COUNT:     timing.pixel_count     = value[COUNT_W-1:0];
      REG_ONE_HIGH_TICKS:  timing.one_high_ticks  = value[TICK_W-1:0];
      REG_ONE_LOW_TICKS:   timing.one_low_ticks   = value[TICK_W-1:0];
      REG_ZERO_HIGH_TICKS: timing.zero_high_ticks = value[TICK_W-1:0];
      REG_ZERO_LOW_TICKS:  timing.zero_low_ticks  = value[TICK_W-1:0];
      default: ;
    endcase
  endtask

  // Zero the whole back bank, regardless of the pixel count
  task automatic blank_back();
    for (int i = 0; i < MAX_PIXELS; i++) begin
      if (front_is_a) begin
        bank_b[i] = '0;
      end else begin
        bank_a[i] = '0;
      end
    end
  endtask

  task automatic reset_strip();
    front_is_a = 1'b1;
    for (int i = 0; i < MAX_PIXELS; i++) begin
      bank_a[i] = '0;
      bank_b[i] = '0;
    end
    timing = '{PIXEL_COUNT_RST, ONE_HIGH_TICKS_RST, ONE_LOW_TICKS_RST,
               ZERO_HIGH_TICKS_RST, ZERO_LOW_TICKS_RST};
  endtask

  // Update the banks for one item and queue the pulse items it must produce
  task automatic predict_pulses(input act_t act, input logic [IDX_W-1:0] idx,
                                input logic [COLOR_W-1:0] red, green, blue);
    int               live;
    logic             in_range;
    logic [GRB_W-1:0] grb;
    pulse_t           p;
    live     = (timing.pixel_count > MAX_PIXELS) ? MAX_PIXELS : int'(timing.pixel_count);
    in_range = int'(idx) < live;
    p        = '{hi_cnt: '0, lo_cnt: '0, last: 1'b1, status: STAT_OK};
    if ((act == ACT_SET || act == ACT_EMIT) && !in_range) begin
      p.status = STAT_RANGE;
      expected_pulses.push_back(p);
      return;
    end
    case (act)
      ACT_SET: begin
        if (front_is_a) begin
          bank_b[idx] = {green, red, blue};
        end else begin
          bank_a[idx] = {green, red, blue};
        end
      end
      ACT_SHOW: begin
        // old front becomes the back bank and is blanked
        front_is_a = !front_is_a;
        blank_back();
      end
      ACT_CLEAR: blank_back();
      default: begin
        grb = front_is_a ? bank_a[idx] : bank_b[idx];
        for (int k = 0; k < PULSES; k++) begin
          if (grb[PULSES-1-k]) begin
            p.hi_cnt = timing.one_high_ticks;
            p.lo_cnt = timing.one_low_ticks;
          end else begin
            p.hi_cnt = timing.zero_high_ticks;
            p.lo_cnt = timing.zero_low_ticks;
          end
          p.last = (k == PULSES - 1);
          expected_pulses.push_back(p);
        end
        return;
      end
    endcase
    expected_pulses.push_back(p);
  endtask

  always @(posedge clk) begin : watch
    logic [REG_SEL_W-1:0] sel;
    pulse_t               got;
    pulse_t               want;
    sel = paddr[APB_ADDR_W-1:2];
    if (rst) begin
      reset_strip();
      expected_pulses.delete();
    end else begin
      // register port
      if (psel && penable && pready) begin
        if (pwrite) begin
          write_reg(sel, pwdata);
        end else if (sel <= REG_ZERO_LOW_TICKS && prdata !== reg_value(sel)) begin
          flag($sformatf("register %0d read: expected %0h, got %0h",
                         sel, reg_value(sel), prdata));
        end
      end
      // incoming item
      if (s_tvalid && s_tready) begin
        predict_pulses(act_t'(s_tuser), s_tdata[IDX_W-1:0],
                       s_tdata[IDX_W+COLOR_W-1:IDX_W],
                       s_tdata[IDX_W+2*COLOR_W-1:IDX_W+COLOR_W],
                       s_tdata[IDX_W+3*COLOR_W-1:IDX_W+2*COLOR_W]);
      end
      // outgoing pulse item
      if (m_tvalid && m_tready) begin
        got = '{hi_cnt: m_tdata[TICK_W-1:0], lo_cnt: m_tdata[2*TICK_W-1:TICK_W],
                last: m_tlast, status: stat_t'(m_tuser)};
        if (expected_pulses.size() == 0) begin
          flag($sformatf("unexpected item: high %0d low %0d last %b status %b",
                         got.hi_cnt, got.lo_cnt, got.last, got.status));
        end else begin
          want = expected_pulses.pop_front();
          if (got !== want) begin
            flag($sformatf({"pulse mismatch: expected high %0d low %0d last %b status %b,",
                            " got high %0d low %0d last %b status %b"},
                           want.hi_cnt, want.lo_cnt, want.last, want.status,
                           got.hi_cnt, got.lo_cnt, got.last, got.status));
          end
        end
      end
    end
    pending_count = expected_pulses.size();
  end

endmodule

@@ tb/double_buffered_led_strip_encoder_test.sv @@
`timescale 1ns / 100ps

module double_buffered_led_strip_encoder_test;
  import dble_pkg::*;

  localparam int                   LONG_HOLD_CYCLES = 400;
  localparam int                   CYCLE_LIMIT      = 500000;
  localparam int                   DRAIN_CYCLES     = 40;
  localparam int                   RANDOM_PHASES    = 6;
  localparam int                   PHASE_ITEMS      = 36;
  localparam logic [REG_SEL_W-1:0] REG_UNUSED       = 3'd5;
  localparam logic [TICK_W-1:0]    TICK_MAX         = '1;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata;   // pixel_index, red, green, blue
  logic [S_USER_W-1:0]   s_tuser;   // action
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_DATA_W-1:0]   m_tdata;   // pulse_high_ticks, pulse_low_ticks
  logic                  m_tuser;   // status
  logic                  m_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int                    fail_count;
  int                    pending_count;
  int                    cycle_count;
  int                    burst_left;
  int                    strip_len;
  logic                  hold_req;

  double_buffered_led_strip_encoder dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  led_strip_pulse_checker pulse_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort on a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("double_buffered_led_strip_encoder_test NOT OK");
    $finish;
  end

  // Pulse receiver: switch between stall patterns, honor a long hold request
  initial begin : pulse_sink
    int mode;
    int mode_left;
    int stall_left;
    m_tready   = 1'b0;
    hold_req   = 1'b0;
    mode       = 0;
    mode_left  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          default: begin
            if (stall_left > 0) begin
              m_tready <= 1'b0;
              stall_left--;
            end else begin
              m_tready   <= 1'b1;
              stall_left = $urandom_range(1, 10);
            end
          end
        endcase
      end
    end
  end

  // Offer one item; open a new burst after a random gap when the old one is used up
  task automatic send_item(input act_t act, input logic [IDX_W-1:0] idx,
                           input logic [COLOR_W-1:0] red, green, blue);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {blue, green, red, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drop valid, wait for every pulse item to drain and the block to go idle
  task automatic settle();
    @(negedge clk);
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (pending_count != 0 || !s_tready) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [REG_SEL_W-1:0] sel,
                            input logic [APB_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr && sel == REG_PIXEL_COUNT) begin
      strip_len = int'(value[COUNT_W-1:0]);
    end
  endtask

  task automatic read_all_regs();
    for (int i = 0; i <= int'(REG_ZERO_LOW_TICKS); i++) begin
      reg_access(1'b0, REG_SEL_W'(i), '0);
    end
  endtask

  function automatic logic [APB_DATA_W-1:0] pick_ticks();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return APB_DATA_W'(TICK_MAX);
      default: return $urandom_range(0, int'(TICK_MAX));
    endcase
  endfunction

  function automatic logic [APB_DATA_W-1:0] pick_count();
    case ($urandom_range(0, 7))
      0:       return 1;
      1:       return MAX_PIXELS;
      2:       return 0;
      3:       return (1 << COUNT_W) - 1;
      4:       return $urandom_range(MAX_PIXELS + 1, (1 << COUNT_W) - 1);
      5:       return $urandom_range(1, MAX_PIXELS);
      default: return $urandom_range(2, 32);
    endcase
  endfunction

  // Mostly in range and clustered low, so emits find drawn pixels
  function automatic logic [IDX_W-1:0] pick_index();
    int live;
    int roll;
    live = (strip_len > MAX_PIXELS) ? MAX_PIXELS : strip_len;
    roll = $urandom_range(0, 9);
    if (live == 0 || roll >= 8) begin
      return IDX_W'($urandom_range(0, MAX_PIXELS - 1));
    end
    if (roll < 5) begin
      return IDX_W'($urandom_range(0, ((live < 12) ? live : 12) - 1));
    end
    return IDX_W'($urandom_range(0, live - 1));
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom_range(0, (1 << COLOR_W) - 1));
    endcase
  endfunction

  function automatic act_t pick_action();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return ACT_SET;
    if (roll < 75) return ACT_EMIT;
    if (roll < 88) return ACT_SHOW;
    return ACT_CLEAR;
  endfunction

  initial begin : stimulus
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = ACT_SET;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    burst_left = 0;
    strip_len  = int'(PIXEL_COUNT_RST);
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // reset values, then the banks with default timing
    read_all_regs();
    send_item(ACT_EMIT, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(ACT_SET, 8'd0, 8'hFF, 8'hFF, 8'hFF);
    send_item(ACT_SET, 8'd255, 8'h00, 8'hA5, 8'h3C);
    send_item(ACT_SET, 8'd128, 8'h80, 8'h01, 8'h7E);
    send_item(ACT_SHOW, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(ACT_EMIT, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(ACT_EMIT, 8'd255, 8'h00, 8'h00, 8'h00);
    send_item(ACT_EMIT, 8'd128, 8'h00, 8'h00, 8'h00);
    send_item(ACT_SET, 8'd7, 8'h01, 8'h02, 8'h03);
    send_item(ACT_CLEAR, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(ACT_SHOW, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(ACT_EMIT, 8'd7, 8'h00, 8'h00, 8'h00);
    send_item(ACT_EMIT, 8'd0, 8'h00, 8'h00, 8'h00);

    // one-pixel strip, extreme timing, a write past the register list
    settle();
    reg_access(1'b1, REG_PIXEL_COUNT, 1);
    reg_access(1'b1, REG_ONE_HIGH_TICKS, APB_DATA_W'(TICK_MAX));
    reg_access(1'b1, REG_ONE_LOW_TICKS, 0);
    reg_access(1'b1, REG_ZERO_HIGH_TICKS, 0);
    reg_access(1'b1, REG_ZERO_LOW_TICKS, APB_DATA_W'(TICK_MAX));
    reg_access(1'b1, REG_UNUSED, '1);
    read_all_regs();
    send_item(ACT_SET, 8'd1, 8'h11, 8'h22, 8'h33);
    send_item(ACT_SET, 8'd0, 8'hFF, 8'h00, 8'hFF);
    send_item(ACT_EMIT, 8'd1, 8'h00, 8'h00, 8'h00);
    send_item(ACT_SHOW, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(ACT_EMIT, 8'd0, 8'h00, 8'h00, 8'h00);

    // zero count puts every index out of range
    settle();
    reg_access(1'b1, REG_PIXEL_COUNT, 0);
    send_item(ACT_SET, 8'd0, 8'h12, 8'h34, 8'h56);
    send_item(ACT_EMIT, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(ACT_SHOW, 8'd0, 8'h00, 8'h00, 8'h00);

    // count above the bank size saturates
    settle();
    reg_access(1'b1, REG_PIXEL_COUNT, (1 << COUNT_W) - 1);
    reg_access(1'b1, REG_ONE_HIGH_TICKS, pick_ticks());
    reg_access(1'b1, REG_ZERO_LOW_TICKS, pick_ticks());
    read_all_regs();
    send_item(ACT_SET, 8'd255, 8'hC3, 8'h5A, 8'h96);
    send_item(ACT_SHOW, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(ACT_EMIT, 8'd255, 8'h00, 8'h00, 8'h00);

    // random phases, each under a fresh register setting
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      reg_access(1'b1, REG_PIXEL_COUNT, (phase == 0) ? MAX_PIXELS : pick_count());
      reg_access(1'b1, REG_ONE_HIGH_TICKS, pick_ticks());
      reg_access(1'b1, REG_ONE_LOW_TICKS, pick_ticks());
      reg_access(1'b1, REG_ZERO_HIGH_TICKS, pick_ticks());
      reg_access(1'b1, REG_ZERO_LOW_TICKS, pick_ticks());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // back the output up so the block stalls its input
        if (phase == 0 && i == 8) begin
          hold_req = 1'b1;
        end
        send_item(pick_action(), pick_index(), pick_color(), pick_color(), pick_color());
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("double_buffered_led_strip_encoder_test OK");
    end else begin
      $display("double_buffered_led_strip_encoder_test NOT OK");
    end
    $finish;
  end

endmodule
